// ===== rtl/core/crc8fd_pkg.sv =====
package crc8fd_pkg;

  // framing constants
  localparam logic [7:0] SOF_BYTE   = 8'hA5;
  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] CRC_TOPBIT = 8'h80;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd256;

  // event codes on the result channel
  localparam logic [1:0] EV_PAYLOAD  = 2'd0;
  localparam logic [1:0] EV_CRC_GOOD = 2'd1;
  localparam logic [1:0] EV_CRC_BAD  = 2'd2;

  // parser phase, one-hot
  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_TYPE = 6'b000010,
    PH_LEN0 = 6'b000100,
    PH_LEN1 = 6'b001000,
    PH_DATA = 6'b010000,
    PH_CRC  = 6'b100000
  } phase_t;

  // one result transaction plus its valid flag
  typedef struct packed {
    logic        valid;
    logic [1:0]  event_kind;
    logic [7:0]  frame_type;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
    logic        oversize;
    logic [7:0]  received_crc;
    logic [7:0]  computed_crc;
  } res_t;

  // crc-8, poly 0x07, msb first, one byte unrolled
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOPBIT) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/crc8_frame_deframer.sv =====
// Frame parser for a byte stream from a serial receiver: hunts for start
// byte 0xA5, then reads type, a little-endian 16-bit length, the payload and
// a CRC-8 (poly 0x07, init 0) over type, length and payload. Each payload
// byte leaves as its own transaction with its index; the CRC byte yields one
// frame-end transaction (good or mismatch, plus oversize against
// max_payload). One byte is taken per cycle unless the output stalls: a
// byte passes through an input register, one pass of parse and CRC logic,
// and a result register, where its result is offered on the output.
// Header and start bytes give no result. in_stall rises only when the input
// register holds a byte and the result register is full and stalled.
module crc8_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_frame_type,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_byte_index,
  output logic [15:0] out_frame_length,
  output logic        out_oversize,
  output logic [7:0]  out_received_crc,
  output logic [7:0]  out_computed_crc,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import crc8fd_pkg::*;

  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  in_byte_r;
  logic [15:0] max_payload_r;
  logic        out_valid_r, out_valid_nxt;
  res_t        out_r;
  res_t        res;
  logic        consume;
  logic        in_take;

  // byte in the input register moves on when the result register can take it
  assign consume  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !consume;
  assign in_take  = in_valid && !in_stall;

  crc8fd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (consume),
    .rx_byte     (in_byte_r),
    .max_payload (max_payload_r),
    .res         (res)
  );

  // input register
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (consume) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // max_payload register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_wr_en) begin
      max_payload_r <= cfg_wr_data;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (consume && res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (consume && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_r.event_kind;
  assign out_frame_type   = out_r.frame_type;
  assign out_payload_byte = out_r.payload_byte;
  assign out_byte_index   = out_r.byte_index;
  assign out_frame_length = out_r.frame_length;
  assign out_oversize     = out_r.oversize;
  assign out_received_crc = out_r.received_crc;
  assign out_computed_crc = out_r.computed_crc;

endmodule

// ===== rtl/core/crc8fd_parser.sv =====
module crc8fd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        rx_byte,
  input  logic [15:0]       max_payload,
  output crc8fd_pkg::res_t  res
);
  import crc8fd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  crc_upd;
  logic [15:0] count_inc;
  logic [15:0] len_full;

  assign crc_upd   = crc8_step(crc_r, rx_byte);
  assign count_inc = count_r + 16'd1;
  assign len_full  = {rx_byte, len_r[7:0]};

  // next state and result for the byte at the input register
  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    crc_nxt   = crc_r;
    res       = '0;
    unique case (phase_r)
      PH_TYPE: begin
        type_nxt  = rx_byte;
        crc_nxt   = crc8_step(8'h00, rx_byte);
        phase_nxt = PH_LEN0;
      end
      PH_LEN0: begin
        len_nxt   = {8'h00, rx_byte};
        crc_nxt   = crc_upd;
        phase_nxt = PH_LEN1;
      end
      PH_LEN1: begin
        len_nxt   = len_full;
        crc_nxt   = crc_upd;
        count_nxt = 16'd0;
        phase_nxt = (len_full == 16'd0) ? PH_CRC : PH_DATA;
      end
      PH_DATA: begin
        crc_nxt            = crc_upd;
        count_nxt          = count_inc;
        res.valid          = 1'b1;
        res.event_kind     = EV_PAYLOAD;
        res.frame_type     = type_r;
        res.payload_byte   = rx_byte;
        res.byte_index     = count_r;
        res.frame_length   = len_r;
        if (count_inc >= len_r) begin
          phase_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        res.valid        = 1'b1;
        res.event_kind   = (rx_byte == crc_r) ? EV_CRC_GOOD : EV_CRC_BAD;
        res.frame_type   = type_r;
        res.frame_length = len_r;
        res.oversize     = (len_r > max_payload);
        res.received_crc = rx_byte;
        res.computed_crc = crc_r;
        phase_nxt        = PH_HUNT;
      end
      default: begin
        phase_nxt = (rx_byte == SOF_BYTE) ? PH_TYPE : PH_HUNT;
      end
    endcase
  end

  // parser state, advances once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      type_r  <= 8'h00;
      len_r   <= 16'd0;
      count_r <= 16'd0;
      crc_r   <= 8'h00;
    end else if (take) begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
    end
  end

`ifndef SYNTHESIS
  // payload index never reaches the declared length
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> count_r < len_r)
    else $error("payload count outside declared length");

  // frame end always returns to hunting
  a_crc_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    take && phase_r == PH_CRC |=> phase_r == PH_HUNT)
    else $error("no return to hunt after crc byte");

  // start byte while hunting opens a frame
  a_sof_opens: assert property (@(posedge clk) disable iff (!rst_n)
    take && phase_r == PH_HUNT && rx_byte == SOF_BYTE |=> phase_r == PH_TYPE)
    else $error("start byte missed");

  // results come only from payload and crc bytes
  a_res_phase: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (phase_r == PH_DATA || phase_r == PH_CRC))
    else $error("result outside payload or crc phase");
`endif

endmodule

// ===== dv/crc8_frame_deframer_checker.sv =====
package crc8fd_tb_pkg;

  import crc8fd_pkg::*;

  // crc-8 shifted in one data bit at a time, msb first
  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[7] ^ data[k];
      r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

endpackage

module crc8_frame_deframer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_event_kind,
  input  logic [7:0]  out_frame_type,
  input  logic [7:0]  out_payload_byte,
  input  logic [15:0] out_byte_index,
  input  logic [15:0] out_frame_length,
  input  logic        out_oversize,
  input  logic [7:0]  out_received_crc,
  input  logic [7:0]  out_computed_crc,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output int          fail_count,
  output int          events_checked,
  output int          expected_left
);

  import crc8fd_pkg::*;
  import crc8fd_tb_pkg::*;

  typedef enum logic [2:0] {
    SEEK_SOF   = 3'd0,
    GET_TYPE   = 3'd1,
    GET_LEN_LO = 3'd2,
    GET_LEN_HI = 3'd3,
    GET_DATA   = 3'd4,
    GET_CRC    = 3'd5
  } parse_step_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ftype;
    logic [7:0]  data;
    logic [15:0] index;
    logic [15:0] length;
    logic        oversize;
    logic [7:0]  rx_crc;
    logic [7:0]  calc_crc;
  } frame_event_t;

  // predictor state
  parse_step_t  step;
  logic [7:0]   cur_type;
  logic [15:0]  cur_len;
  logic [15:0]  data_count;
  logic [7:0]   crc_acc;
  logic [15:0]  max_payload;
  frame_event_t pending_events[$];
  frame_event_t seen;
  frame_event_t want;

  initial begin
    fail_count = 0;
    events_checked = 0;
    expected_left = 0;
  end

  task automatic report(input string msg);
    $display("[%0t] checker: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      report($sformatf("%s mismatch on result %0d: expected %h, got %h",
                       name, events_checked, exp_v, got_v));
    end
  endtask

  // advance the parser model by one accepted byte
  task automatic parse_byte(input logic [7:0] b);
    frame_event_t ev;
    ev = '0;
    case (step)
      GET_TYPE: begin
        cur_type = b;
        crc_acc = crc8_next(8'h00, b);
        step = GET_LEN_LO;
      end
      GET_LEN_LO: begin
        cur_len = {8'h00, b};
        crc_acc = crc8_next(crc_acc, b);
        step = GET_LEN_HI;
      end
      GET_LEN_HI: begin
        cur_len = {b, cur_len[7:0]};
        crc_acc = crc8_next(crc_acc, b);
        data_count = '0;
        step = (cur_len == 16'd0) ? GET_CRC : GET_DATA;
      end
      GET_DATA: begin
        crc_acc = crc8_next(crc_acc, b);
        ev.kind = EV_PAYLOAD;
        ev.ftype = cur_type;
        ev.data = b;
        ev.index = data_count;
        ev.length = cur_len;
        pending_events.push_back(ev);
        data_count = data_count + 16'd1;
        if (data_count >= cur_len) begin
          step = GET_CRC;
        end
      end
      GET_CRC: begin
        ev.kind = (b == crc_acc) ? EV_CRC_GOOD : EV_CRC_BAD;
        ev.ftype = cur_type;
        ev.length = cur_len;
        ev.oversize = (cur_len > max_payload);
        ev.rx_crc = b;
        ev.calc_crc = crc_acc;
        pending_events.push_back(ev);
        step = SEEK_SOF;
      end
      // hunting, and any stray code
      default: begin
        step = (b == SOF_BYTE) ? GET_TYPE : SEEK_SOF;
      end
    endcase
  endtask

  // compare result transactions, then predict from input transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      step = SEEK_SOF;
      cur_type = '0;
      cur_len = '0;
      data_count = '0;
      crc_acc = '0;
      max_payload = MAX_PAYLOAD_RST;
      pending_events.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen = '{out_event_kind, out_frame_type, out_payload_byte, out_byte_index,
                 out_frame_length, out_oversize, out_received_crc, out_computed_crc};
        if (pending_events.size() == 0) begin
          report($sformatf("result with nothing expected: kind %0d type %h index %0d",
                           out_event_kind, out_frame_type, out_byte_index));
        end else begin
          want = pending_events.pop_front();
          check_field("event_kind", 16'(want.kind), 16'(seen.kind));
          check_field("frame_type", 16'(want.ftype), 16'(seen.ftype));
          check_field("payload_byte", 16'(want.data), 16'(seen.data));
          check_field("byte_index", want.index, seen.index);
          check_field("frame_length", want.length, seen.length);
          check_field("oversize", 16'(want.oversize), 16'(seen.oversize));
          check_field("received_crc", 16'(want.rx_crc), 16'(seen.rx_crc));
          check_field("computed_crc", 16'(want.calc_crc), 16'(seen.calc_crc));
          events_checked++;
        end
      end
      if (cfg_wr_en) begin
        max_payload = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        parse_byte(in_rx_byte);
      end
    end
    expected_left <= pending_events.size();
  end

endmodule

// ===== dv/crc8_frame_deframer_test.sv =====
module crc8_frame_deframer_test;

  import crc8fd_pkg::*;
  import crc8fd_tb_pkg::*;

  localparam int SETTLE      = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BYTES = 140;
  localparam int LONG_LEN    = 60;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_event_kind;
  logic [7:0]  out_frame_type;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_byte_index;
  logic [15:0] out_frame_length;
  logic        out_oversize;
  logic [7:0]  out_received_crc;
  logic [7:0]  out_computed_crc;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;

  int fail_count;
  int events_checked;
  int expected_left;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;

  int frames_sent = 0;
  int bad_frames = 0;
  int frame_bytes = 0;
  int stray_bytes = 0;
  logic [7:0] body_q[$];
  logic [15:0] max_small;

  crc8_frame_deframer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_frame_type   (out_frame_type),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_oversize     (out_oversize),
    .out_received_crc (out_received_crc),
    .out_computed_crc (out_computed_crc),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  crc8_frame_deframer_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_frame_type   (out_frame_type),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_oversize     (out_oversize),
    .out_received_crc (out_received_crc),
    .out_computed_crc (out_computed_crc),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .fail_count       (fail_count),
    .events_checked   (events_checked),
    .expected_left    (expected_left)
  );

  always #5 clk = ~clk;

  // receiver back-pressure: random stalls, or a long counted hold when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      holds_served <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_asked;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // offer one byte, with random idle cycles ahead, and wait for acceptance
  task automatic put_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // start, type, length, payload, check byte; payload from body_q first
  task automatic send_frame(input logic [7:0] ftype, input int len, input bit crc_ok);
    logic [15:0] lenv;
    logic [7:0]  acc;
    logic [7:0]  b;
    lenv = 16'(len);
    acc = crc8_next(8'h00, ftype);
    acc = crc8_next(acc, lenv[7:0]);
    acc = crc8_next(acc, lenv[15:8]);
    put_byte(SOF_BYTE);
    put_byte(ftype);
    put_byte(lenv[7:0]);
    put_byte(lenv[15:8]);
    for (int i = 0; i < len; i++) begin
      b = (body_q.size() != 0) ? body_q.pop_front() : 8'($urandom);
      acc = crc8_next(acc, b);
      put_byte(b);
    end
    if (crc_ok) begin
      put_byte(acc);
    end else begin
      put_byte(acc ^ 8'($urandom_range(1, 255)));
      bad_frames++;
    end
    frames_sent++;
    frame_bytes += len + 5;
  endtask

  // stop offering until every expected transaction has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_max(input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // mostly well-formed frames with random content, some line noise
  task automatic run_random(input int target);
    int start;
    int len;
    int n;
    bit ok;
    logic [7:0] b;
    start = frame_bytes;
    while (frame_bytes - start < target) begin
      if ($urandom_range(99) < 10) begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          b = 8'($urandom);
          if (b == SOF_BYTE) b = ~b;
          put_byte(b);
          stray_bytes++;
        end
      end else begin
        len = ($urandom_range(99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 40);
        ok = ($urandom_range(99) < 80);
        send_frame(8'($urandom), len, ok);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 24;
    recv_idle_pct = 56;

    // directed: noise while hunting, zero length, extreme bytes, bad check byte
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h5A);
    stray_bytes += 3;
    send_frame(8'h00, 0, 1'b1);
    body_q = '{8'hFF};
    send_frame(8'hFF, 1, 1'b0);
    body_q = '{8'h00, 8'hA5, 8'hFF};
    send_frame(SOF_BYTE, 3, 1'b1);
    send_frame(8'h3C, 0, 1'b0);
    wait_idle();

    // every nonzero length is oversize here
    write_max(16'h0000);
    run_random(PHASE_BYTES);
    wait_idle();

    send_idle_pct = 56;
    recv_idle_pct = 24;
    write_max(16'hFFFF);
    run_random(PHASE_BYTES);
    wait_idle();

    // long receiver hold while a long frame keeps coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    max_small = 16'($urandom_range(1, 20));
    write_max(max_small);
    holds_asked <= holds_asked + 1;
    send_frame(8'($urandom), LONG_LEN, 1'b1);
    wait_idle();
    run_random(PHASE_BYTES);
    wait_idle();

    // back to the reset limit, then a maximum declared length left unfinished
    write_max(MAX_PAYLOAD_RST);
    put_byte(SOF_BYTE);
    put_byte(8'($urandom));
    put_byte(8'hFF);
    put_byte(8'hFF);
    repeat (40) put_byte(8'($urandom));
    frame_bytes += 44;
    wait_idle();

    $display("run covered %0d complete frames (%0d with a corrupted check byte), %0d noise bytes",
             frames_sent, bad_frames, stray_bytes);
    $display("%0d frame bytes sent, %0d result transactions compared, limits 256/0/65535/%0d",
             frame_bytes, events_checked, max_small);
    if (fail_count == 0) begin
      $display("crc8_frame_deframer regression: pass");
    end else begin
      $display("crc8_frame_deframer regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d results still expected", expected_left);
    $display("crc8_frame_deframer regression: fail");
    $finish;
  end

endmodule
